// ===== rtl/pkmrl_pkg.sv =====
`timescale 1ns / 1ps

package pkmrl_pkg;

  localparam int NUM_SLOTS_DEF   = 64;
  localparam int PROBE_LIMIT_DEF = 8;

  localparam int KEY_W = 64;
  localparam int TIME_W = 64;
  localparam int IVL_W = 32;

  localparam int MOD_STEP = 8;
  localparam int MOD_CYCLES = KEY_W / MOD_STEP;
  localparam int MCNT_W = $clog2(MOD_CYCLES);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_PROBE,
    ST_FINISH
  } state_t;

endpackage

// ===== rtl/per_key_message_rate_limiter.sv =====
`timescale 1ns / 1ps

// Per-key message rate limiter. Each input beat carries a key hash, the current time in
// milliseconds and a minimum interval; one output beat follows with emit set when the message
// may go out. Keys and last emit times live in a single slot memory of NUM_SLOTS entries,
// probed linearly from key_hash mod NUM_SLOTS for at most PROBE_LIMIT slots; a key not found
// claims an empty slot or replaces the oldest visited one. Items are handled one at a time:
// the remainder is formed 8 key bits per cycle, the probe issues one memory read per cycle
// into a registered read port, and the write-back waits in the finish state until the
// output register is free. After reset the memory is cleared one slot per cycle, and no
// input is accepted until every slot is cleared. A key hash of zero is handled as key hash
// one. The output register lets a new item be accepted while the previous result still
// waits.

module per_key_message_rate_limiter #(
  parameter int NUM_SLOTS   = pkmrl_pkg::NUM_SLOTS_DEF,
  parameter int PROBE_LIMIT = pkmrl_pkg::PROBE_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pkmrl_pkg::KEY_W-1:0]   key_hash,
  input  logic [pkmrl_pkg::TIME_W-1:0]  now_ms,
  input  logic [pkmrl_pkg::IVL_W-1:0]   min_interval,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          emit
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PCNT_W = $clog2(PROBE_LIMIT + 1);
  localparam int KEY_W  = pkmrl_pkg::KEY_W;
  localparam int TIME_W = pkmrl_pkg::TIME_W;
  localparam int IVL_W  = pkmrl_pkg::IVL_W;
  localparam int MEM_W  = KEY_W + TIME_W;
  localparam int MOD_STEP = pkmrl_pkg::MOD_STEP;
  localparam int MCNT_W = pkmrl_pkg::MCNT_W;

  localparam logic [SLOT_W:0]   N_VAL    = (SLOT_W + 1)'(NUM_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

  pkmrl_pkg::state_t state, state_next;

  logic [MEM_W-1:0]  mem [NUM_SLOTS];
  logic [MEM_W-1:0]  rd_data;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  logic [MEM_W-1:0]  mem_wdata;

  logic [KEY_W-1:0]  key_r;
  logic [TIME_W-1:0] now_r;
  logic [IVL_W-1:0]  ivl_r;
  logic [KEY_W-1:0]  key_sh;
  logic [MCNT_W-1:0] mod_cnt;
  logic [SLOT_W-1:0] rem;
  logic [SLOT_W-1:0] rem_c;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] idx_inc;
  logic [PCNT_W-1:0] iss_cnt;
  logic [PCNT_W-1:0] chk_cnt;
  logic              rd_vld;
  logic [SLOT_W-1:0] rd_idx;
  logic [SLOT_W-1:0] victim_idx;
  logic [TIME_W-1:0] victim_time;
  logic              have_victim;
  logic [SLOT_W-1:0] chosen;
  logic [TIME_W-1:0] hit_time;
  logic              fresh;
  logic [SLOT_W-1:0] clr_idx;

  logic [KEY_W-1:0]  rd_key;
  logic [TIME_W-1:0] rd_time;
  logic              hit_match;
  logic              hit_empty;
  logic              take_victim;
  logic [SLOT_W-1:0] vic_idx_c;
  logic              last_chk;
  logic              probe_done;
  logic              mod_last;
  logic              issue_now;
  logic              out_free;
  logic              emit_c;
  logic              in_acc;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[idx];
  end

  assign rd_key  = rd_data[MEM_W-1:TIME_W];
  assign rd_time = rd_data[TIME_W-1:0];

  always_comb begin
    logic [SLOT_W-1:0] r;
    logic [SLOT_W:0]   t;
    r = rem;
    for (int i = 0; i < MOD_STEP; i++) begin
      t = {r, key_sh[KEY_W-1-i]};
      if (t >= N_VAL) begin
        t = t - N_VAL;
      end
      r = t[SLOT_W-1:0];
    end
    rem_c = r;
  end

  assign idx_inc     = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  assign hit_match   = rd_vld && (rd_key == key_r);
  assign hit_empty   = rd_vld && (rd_key == '0);
  assign take_victim = !have_victim || (rd_time < victim_time);
  assign vic_idx_c   = take_victim ? rd_idx : victim_idx;
  assign last_chk    = chk_cnt == PCNT_W'(PROBE_LIMIT - 1);
  assign probe_done  = rd_vld && (hit_match || hit_empty || last_chk);
  assign mod_last    = mod_cnt == MCNT_W'(pkmrl_pkg::MOD_CYCLES - 1);
  assign out_free    = !out_valid || out_ready;
  assign emit_c      = fresh || ((now_r - hit_time) >= {{(TIME_W - IVL_W){1'b0}}, ivl_r});
  assign in_acc      = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      pkmrl_pkg::ST_CLEAR: begin
        if (clr_idx == LAST_IDX) begin
          state_next = pkmrl_pkg::ST_IDLE;
        end
      end
      pkmrl_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = pkmrl_pkg::ST_MOD;
        end
      end
      pkmrl_pkg::ST_MOD: begin
        if (mod_last) begin
          state_next = pkmrl_pkg::ST_PROBE;
        end
      end
      pkmrl_pkg::ST_PROBE: begin
        if (probe_done) begin
          state_next = pkmrl_pkg::ST_FINISH;
        end
      end
      pkmrl_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = pkmrl_pkg::ST_IDLE;
        end
      end
      default: state_next = pkmrl_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = chosen;
    mem_wdata = {key_r, now_r};
    issue_now = 1'b0;
    unique case (state)
      pkmrl_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = '0;
      end
      pkmrl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      pkmrl_pkg::ST_MOD: begin
      end
      pkmrl_pkg::ST_PROBE: begin
        issue_now = (iss_cnt < PCNT_W'(PROBE_LIMIT)) && !probe_done;
      end
      pkmrl_pkg::ST_FINISH: begin
        mem_we = out_free && emit_c;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pkmrl_pkg::ST_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
      rd_vld    <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue_now;
      if (state == pkmrl_pkg::ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (state == pkmrl_pkg::ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r   <= (key_hash == '0) ? KEY_W'(1) : key_hash;
      key_sh  <= (key_hash == '0) ? KEY_W'(1) : key_hash;
      now_r   <= now_ms;
      ivl_r   <= min_interval;
      rem     <= '0;
      mod_cnt <= '0;
    end
    if (state == pkmrl_pkg::ST_MOD) begin
      key_sh  <= {key_sh[KEY_W-MOD_STEP-1:0], MOD_STEP'(0)};
      rem     <= rem_c;
      mod_cnt <= mod_cnt + 1'b1;
      if (mod_last) begin
        idx         <= rem_c;
        iss_cnt     <= '0;
        chk_cnt     <= '0;
        have_victim <= 1'b0;
      end
    end
    if (issue_now) begin
      idx     <= idx_inc;
      rd_idx  <= idx;
      iss_cnt <= iss_cnt + 1'b1;
    end
    if (state == pkmrl_pkg::ST_PROBE && rd_vld) begin
      chk_cnt     <= chk_cnt + 1'b1;
      victim_idx  <= vic_idx_c;
      victim_time <= take_victim ? rd_time : victim_time;
      have_victim <= 1'b1;
      if (probe_done) begin
        chosen   <= (hit_match || hit_empty) ? rd_idx : vic_idx_c;
        fresh    <= !hit_match;
        hit_time <= rd_time;
      end
    end
    if (state == pkmrl_pkg::ST_FINISH && out_free) begin
      emit <= emit_c;
    end
  end

endmodule

// ===== dv/tb_per_key_message_rate_limiter.sv =====
`timescale 1ns / 1ps

module tb_per_key_message_rate_limiter;

  import pkmrl_pkg::*;

  localparam int SLOTS  = NUM_SLOTS_DEF;
  localparam int PROBES = PROBE_LIMIT_DEF;
  localparam int RANDOM_BEATS = 730;
  localparam int HOT_KEYS = 20;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] stamp;
    logic [IVL_W-1:0]  ivl;
    logic              typed;
    logic              emit;
  } probe_row_t;

  localparam int PLAN_LEN = 23;
  localparam probe_row_t PLAN [PLAN_LEN] = '{
    '{64'd1, 64'd0, 32'd0, 1'b1, 1'b1},
    '{64'd1, 64'd0, 32'd1, 1'b1, 1'b0},
    // zero hash lands on key one
    '{64'd0, 64'd5, 32'd5, 1'b1, 1'b1},
    '{64'd1, 64'd9, 32'd5, 1'b1, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1},
    // time steps backwards, difference wraps large
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF5, 32'hFFFF_FFFF, 1'b1, 1'b1},
    // time wraps forwards past zero
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'd4, 32'd16, 1'b1, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'd4, 32'd15, 1'b1, 1'b1},
    // fill the whole probe run from slot two
    '{64'h042, 64'd10, 32'd0, 1'b1, 1'b1},
    '{64'h082, 64'd11, 32'd0, 1'b1, 1'b1},
    '{64'h0C2, 64'd12, 32'd0, 1'b1, 1'b1},
    '{64'h102, 64'd13, 32'd0, 1'b1, 1'b1},
    '{64'h142, 64'd14, 32'd0, 1'b1, 1'b1},
    '{64'h182, 64'd15, 32'd0, 1'b1, 1'b1},
    '{64'h1C2, 64'd16, 32'd0, 1'b1, 1'b1},
    '{64'h202, 64'd17, 32'd0, 1'b1, 1'b1},
    // evict the oldest visited slot
    '{64'h242, 64'd18, 32'd0, 1'b1, 1'b1},
    '{64'h042, 64'd19, 32'hFFFF_FFFF, 1'b0, 1'b0},
    '{64'h082, 64'd20, 32'hFFFF_FFFF, 1'b0, 1'b0},
    '{64'h0C2, 64'd20, 32'd10, 1'b0, 1'b0},
    '{64'h8000_0000_0000_003F, 64'd21, 32'd0, 1'b0, 1'b0},
    '{64'h8000_0000_0000_0001, 64'd22, 32'd7, 1'b0, 1'b0},
    '{64'h0C2, 64'd0, 32'd0, 1'b1, 1'b1}
  };

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [KEY_W-1:0]  key_hash;
  logic [TIME_W-1:0] now_ms;
  logic [IVL_W-1:0]  min_interval;
  logic              out_valid;
  logic              out_ready;
  logic              emit;

  logic [KEY_W-1:0]  seen_key   [SLOTS];
  logic [TIME_W-1:0] seen_stamp [SLOTS];
  logic [KEY_W-1:0]  hot_key    [HOT_KEYS];
  bit                emit_due [$];
  int                errors;
  int                beats_out;
  bit                calm;
  bit                held;

  per_key_message_rate_limiter #(
    .NUM_SLOTS   (SLOTS),
    .PROBE_LIMIT (PROBES)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .key_hash     (key_hash),
    .now_ms       (now_ms),
    .min_interval (min_interval),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .emit         (emit)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic bit admit_message(logic [KEY_W-1:0] hash, logic [TIME_W-1:0] stamp,
                                       logic [IVL_W-1:0] ivl);
    logic [KEY_W-1:0]  k;
    logic [TIME_W-1:0] oldest_t;
    int unsigned       base;
    int unsigned       idx;
    int unsigned       pick;
    int unsigned       oldest;
    bit                hit;
    bit                fresh;
    bit                have_old;
    bit                go;
    k = (hash == '0) ? KEY_W'(1) : hash;
    base = int'(k % SLOTS);
    pick = base;
    oldest = base;
    oldest_t = '0;
    hit = 1'b0;
    fresh = 1'b0;
    have_old = 1'b0;
    for (int p = 0; p < PROBES && !hit; p++) begin
      idx = (base + p) % SLOTS;
      if (seen_key[idx] == k) begin
        pick = idx;
        hit = 1'b1;
      end else if (seen_key[idx] == '0) begin
        seen_key[idx] = k;
        pick = idx;
        hit = 1'b1;
        fresh = 1'b1;
      end else if (!have_old || seen_stamp[idx] < oldest_t) begin
        oldest = idx;
        oldest_t = seen_stamp[idx];
        have_old = 1'b1;
      end
    end
    if (!hit) begin
      pick = have_old ? oldest : base;
      seen_key[pick] = k;
      fresh = 1'b1;
    end
    go = fresh || ((stamp - seen_stamp[pick]) >= TIME_W'(ivl));
    if (go) begin
      seen_stamp[pick] = stamp;
    end
    return go;
  endfunction

  task automatic offer_beat(logic [KEY_W-1:0] k, logic [TIME_W-1:0] stamp,
                            logic [IVL_W-1:0] ivl, bit typed, bit typed_emit);
    bit predicted;
    while (!calm && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    key_hash     <= k;
    now_ms       <= stamp;
    min_interval <= ivl;
    do @(posedge clk); while (!in_ready);
    predicted = admit_message(k, stamp, ivl);
    emit_due.push_back(typed ? typed_emit : predicted);
    @(negedge clk);
  endtask

  initial begin
    out_ready = 1'b0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && beats_out >= 120) begin
        // hold off the output so the block backs up into its input
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 11);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      beats_out <= beats_out + 1;
      if (emit_due.size() == 0) begin
        $error("emit: expected none, got %0b", emit);
        errors++;
      end else begin
        if (emit !== emit_due[0]) begin
          $error("emit: expected %0b, got %0b", emit_due[0], emit);
          errors++;
        end
        void'(emit_due.pop_front());
      end
    end
  end

  initial begin
    #1_000_000;
    $display("tb_per_key_message_rate_limiter: errors");
    $finish;
  end

  initial begin
    logic [TIME_W-1:0] clock_ms;
    logic [TIME_W-1:0] stamp;
    logic [KEY_W-1:0]  k;
    logic [IVL_W-1:0]  ivl;
    logic [5:0]        lanes [4];
    int                r;
    rst = 1'b1;
    in_valid = 1'b0;
    key_hash = '0;
    now_ms = '0;
    min_interval = '0;
    errors = 0;
    beats_out = 0;
    calm = 1'b0;
    clock_ms = 64'd1000;
    lanes = '{6'd61, 6'd62, 6'd63, 6'd0};
    for (int i = 0; i < SLOTS; i++) begin
      seen_key[i] = '0;
      seen_stamp[i] = '0;
    end
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < PLAN_LEN; i++) begin
      offer_beat(PLAN[i].key, PLAN[i].stamp, PLAN[i].ivl, PLAN[i].typed, PLAN[i].emit);
    end

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 250 == 0) begin
        // crowd a few neighbouring home slots across the wrap so probes overflow
        for (int j = 0; j < HOT_KEYS; j++) begin
          hot_key[j] = {$urandom, $urandom};
          hot_key[j][5:0] = lanes[j % 4];
        end
      end
      calm = (n >= 300 && n < 450);
      if (n == 500) begin
        // drain the block before carrying on
        in_valid <= 1'b0;
        @(negedge clk);
        while (emit_due.size() != 0) @(negedge clk);
      end
      r = $urandom_range(0, 99);
      k = hot_key[$urandom_range(0, HOT_KEYS - 1)];
      if (r < 10) begin
        k = {$urandom, $urandom};
        stamp = {$urandom, $urandom};
        ivl = $urandom;
      end else begin
        if (r < 15) begin
          stamp = clock_ms - $urandom_range(1, 50);
        end else begin
          clock_ms = clock_ms + $urandom_range(0, 12);
          stamp = clock_ms;
        end
        case ($urandom_range(0, 19))
          0:       ivl = '0;
          1:       ivl = '1;
          default: ivl = $urandom_range(1, 30);
        endcase
      end
      offer_beat(k, stamp, ivl, 1'b0, 1'b0);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (emit_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("tb_per_key_message_rate_limiter: clean");
    end else begin
      $display("tb_per_key_message_rate_limiter: errors");
    end
    $finish;
  end

endmodule
